### src/bitcrush_quantize_hold_mix_assert.svh
// Assertion macros for the bitcrusher block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef BITCRUSH_QUANTIZE_HOLD_MIX_ASSERT_SVH
`define BITCRUSH_QUANTIZE_HOLD_MIX_ASSERT_SVH

`ifndef SYNTHESIS
`define BQHM_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);
`define BQHM_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);
`else
`define BQHM_ASSERT_SAME(lbl, ant, cons, msg)
`define BQHM_ASSERT_NEXT(lbl, ant, cons, msg)
`endif

`endif

### src/bqhm_pkg.sv
`default_nettype none

package bqhm_pkg;

  localparam int unsigned BIT_DEPTH_W = 5;
  localparam int unsigned HOLD_LEN_W  = 6;
  localparam int unsigned WET_MIX_W   = 11;
  localparam int unsigned HOLD_CNT_W  = 5;

  localparam int unsigned BITS_MIN  = 1;
  localparam int unsigned BITS_MAX  = 16;
  localparam int unsigned HOLD_MIN  = 1;
  localparam int unsigned HOLD_MAX  = 32;
  localparam int unsigned MIX_ONE   = 1024;
  localparam int unsigned MIX_SHIFT = 10;
  localparam int unsigned MIX_HALF  = MIX_ONE / 2;

  localparam logic [BIT_DEPTH_W-1:0] BIT_DEPTH_RST = BIT_DEPTH_W'(8);
  localparam logic [HOLD_LEN_W-1:0]  HOLD_LEN_RST  = HOLD_LEN_W'(1);
  localparam logic [WET_MIX_W-1:0]   WET_MIX_RST   = WET_MIX_W'(MIX_ONE);

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_BIT_DEPTH   = 2'd0,
    REG_HOLD_LENGTH = 2'd1,
    REG_WET_MIX     = 2'd2
  } reg_idx_e;

endpackage

`default_nettype wire

### src/bqhm_quant.sv
`default_nettype none

module bqhm_quant
  import bqhm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic [BIT_DEPTH_W-1:0]         bit_depth_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] quant_o
);

  localparam int BitsTop = (BITS_MAX < SAMPLE_WIDTH) ? BITS_MAX : SAMPLE_WIDTH;
  localparam int ShW     = $clog2(SAMPLE_WIDTH);

  logic [BIT_DEPTH_W-1:0]  bits;
  logic [ShW-1:0]          shift;
  logic                    neg;
  logic [SAMPLE_WIDTH-1:0] mag;
  logic [SAMPLE_WIDTH-1:0] step_mask;
  logic [SAMPLE_WIDTH-1:0] low_mask;
  logic [SAMPLE_WIDTH-1:0] half;
  logic [SAMPLE_WIDTH:0]   rnd;
  logic [SAMPLE_WIDTH:0]   rnd_neg;
  logic [SAMPLE_WIDTH:0]   max_code;

  always_comb begin
    if (bit_depth_i < BIT_DEPTH_W'(BITS_MIN)) begin
      bits = BIT_DEPTH_W'(BITS_MIN);
    end else if (bit_depth_i > BIT_DEPTH_W'(BitsTop)) begin
      bits = BIT_DEPTH_W'(BitsTop);
    end else begin
      bits = bit_depth_i;
    end
    shift = ShW'(SAMPLE_WIDTH - int'(bits));

    // round the magnitude half away from zero onto the step grid
    neg       = sample_i[SAMPLE_WIDTH-1];
    mag       = neg ? (~sample_i) + SAMPLE_WIDTH'(1) : sample_i;
    step_mask = {SAMPLE_WIDTH{1'b1}} << shift;
    low_mask  = ~step_mask;
    half      = low_mask ^ (low_mask >> 1);
    rnd       = ({1'b0, mag} + {1'b0, half}) & {1'b1, step_mask};
    rnd_neg   = (~rnd) + (SAMPLE_WIDTH + 1)'(1);
    max_code  = {2'b00, {(SAMPLE_WIDTH-1){1'b1}}};

    if (neg) begin
      quant_o = rnd_neg[SAMPLE_WIDTH-1:0];
    end else if (rnd > max_code) begin
      // +1.0 saturates to the largest code
      quant_o = max_code[SAMPLE_WIDTH-1:0];
    end else begin
      quant_o = rnd[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

### src/bitcrush_quantize_hold_mix.sv
// Bitcrusher with per-channel sample-and-hold and dry/wet blend.
// Input channel: in_valid_i/in_ready_o carries channel_i and a signed
// sample_in_i. Output channel: out_valid_o/out_ready_i carries channel_out_o
// and sample_out_o, one result beat per input beat, in order.
// Pipeline: input register, quantize and hold update, two multipliers,
// sum and round into the output register. One beat is taken every cycle
// unless the output stalls, the rate set by the per-channel hold state
// being read and written in a single stage.
// A stalled receiver freezes the whole pipeline: in_ready_o drops while a
// result waits unaccepted, and no beat is lost or duplicated.
// Registers sit on an APB-style port: bit_depth at 0x0, hold_length at 0x4,
// wet_mix at 0x8; write them only while the pipeline is empty.
// Reset clears the pipeline, sets bit_depth 8, hold_length 1, wet_mix 1024,
// and zeroes every channel's hold counter and held value.
// Channels at or above CHANNELS pass the dry sample and touch no state.
`default_nettype none

`include "bitcrush_quantize_hold_mix_assert.svh"

module bitcrush_quantize_hold_mix
  import bqhm_pkg::*;
#(
  parameter int CHANNELS     = 2,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_ADDR_W-1:0]       paddr,
  input  logic [APB_DATA_W-1:0]       pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  output logic                        pready,

  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] channel_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_in_i,

  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] channel_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]        sample_out_o
);

  localparam int ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CoefW = WET_MIX_W + 1;
  localparam int ProdW = SAMPLE_WIDTH + CoefW;
  localparam int SumW  = ProdW + 1;

  // configuration registers
  logic [BIT_DEPTH_W-1:0] bit_depth_q;
  logic [HOLD_LEN_W-1:0]  hold_len_q;
  logic [WET_MIX_W-1:0]   wet_mix_q;
  logic                   cfg_we;
  logic [1:0]             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_depth_q <= BIT_DEPTH_RST;
      hold_len_q  <= HOLD_LEN_RST;
      wet_mix_q   <= WET_MIX_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BIT_DEPTH:   bit_depth_q <= pwdata[BIT_DEPTH_W-1:0];
        REG_HOLD_LENGTH: hold_len_q  <= pwdata[HOLD_LEN_W-1:0];
        REG_WET_MIX:     wet_mix_q   <= pwdata[WET_MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BIT_DEPTH:   prdata = APB_DATA_W'(bit_depth_q);
      REG_HOLD_LENGTH: prdata = APB_DATA_W'(hold_len_q);
      REG_WET_MIX:     prdata = APB_DATA_W'(wet_mix_q);
      default:         prdata = '0;
    endcase
  end

  // pipeline advance: every stage moves unless the output beat is stalled
  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // input register
  logic                          s0_valid_q;
  logic [ChW-1:0]                s0_ch_q;
  logic signed [SAMPLE_WIDTH-1:0] s0_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s0_ch_q     <= channel_i;
      s0_sample_q <= sample_in_i;
    end
  end

  // quantize and hold update
  logic signed [SAMPLE_WIDTH-1:0] quant;
  logic [HOLD_CNT_W-1:0]          hold_cnt_q [CHANNELS];
  logic signed [SAMPLE_WIDTH-1:0] held_q     [CHANNELS];
  logic                           in_range;
  logic [ChW-1:0]                 idx;
  logic [HOLD_LEN_W-1:0]          hold_eff;
  logic [WET_MIX_W-1:0]           mix_eff;
  logic                           capture;
  logic [HOLD_CNT_W-1:0]          cnt_d;
  logic signed [SAMPLE_WIDTH-1:0] held_d;
  logic signed [SAMPLE_WIDTH-1:0] wet_src;
  logic                           state_we;

  bqhm_quant #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_quant (
    .bit_depth_i(bit_depth_q),
    .sample_i   (s0_sample_q),
    .quant_o    (quant)
  );

  always_comb begin
    in_range = int'(s0_ch_q) < CHANNELS;
    idx      = in_range ? s0_ch_q : '0;

    if (hold_len_q < HOLD_LEN_W'(HOLD_MIN)) begin
      hold_eff = HOLD_LEN_W'(HOLD_MIN);
    end else if (hold_len_q > HOLD_LEN_W'(HOLD_MAX)) begin
      hold_eff = HOLD_LEN_W'(HOLD_MAX);
    end else begin
      hold_eff = hold_len_q;
    end

    mix_eff = (wet_mix_q > WET_MIX_W'(MIX_ONE)) ? WET_MIX_W'(MIX_ONE) : wet_mix_q;

    capture = (hold_eff <= HOLD_LEN_W'(HOLD_MIN)) || (hold_cnt_q[idx] == '0);
    if (capture) begin
      cnt_d  = HOLD_CNT_W'(hold_eff - HOLD_LEN_W'(1));
      held_d = quant;
    end else begin
      cnt_d  = hold_cnt_q[idx] - HOLD_CNT_W'(1);
      held_d = held_q[idx];
    end

    // out-of-range channel: blend dry with itself, which gives dry exactly
    wet_src  = in_range ? held_d : s0_sample_q;
    state_we = adv && s0_valid_q && in_range;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hold_cnt_q[i] <= '0;
        held_q[i]     <= '0;
      end
    end else if (state_we) begin
      hold_cnt_q[idx] <= cnt_d;
      held_q[idx]     <= held_d;
    end
  end

  logic                           s1_valid_q;
  logic [ChW-1:0]                 s1_ch_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_dry_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_wet_q;
  logic [WET_MIX_W-1:0]           s1_mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s0_valid_q) begin
      s1_ch_q  <= s0_ch_q;
      s1_dry_q <= s0_sample_q;
      s1_wet_q <= wet_src;
      s1_mix_q <= mix_eff;
    end
  end

  // weight the dry and held values
  logic signed [CoefW-1:0] dry_coef;
  logic signed [CoefW-1:0] wet_coef;
  logic signed [ProdW-1:0] prod_dry_d;
  logic signed [ProdW-1:0] prod_wet_d;

  assign dry_coef   = signed'({1'b0, WET_MIX_W'(MIX_ONE) - s1_mix_q});
  assign wet_coef   = signed'({1'b0, s1_mix_q});
  assign prod_dry_d = dry_coef * s1_dry_q;
  assign prod_wet_d = wet_coef * s1_wet_q;

  logic                    s2_valid_q;
  logic [ChW-1:0]          s2_ch_q;
  logic signed [ProdW-1:0] s2_prod_dry_q;
  logic signed [ProdW-1:0] s2_prod_wet_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      s2_ch_q       <= s1_ch_q;
      s2_prod_dry_q <= prod_dry_d;
      s2_prod_wet_q <= prod_wet_d;
    end
  end

  // sum and round half away from zero
  logic signed [SumW-1:0]         mix_sum;
  logic signed [SumW-1:0]         mix_rnd;
  logic signed [SumW-1:0]         mix_shr;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_d;

  always_comb begin
    mix_sum = SumW'(s2_prod_dry_q) + SumW'(s2_prod_wet_q);
    if (mix_sum[SumW-1]) begin
      mix_rnd = mix_sum + SumW'(MIX_HALF - 1);
    end else begin
      mix_rnd = mix_sum + SumW'(MIX_HALF);
    end
    mix_shr      = mix_rnd >>> MIX_SHIFT;
    sample_out_d = mix_shr[SAMPLE_WIDTH-1:0];
  end

  logic [ChW-1:0]                 channel_out_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      channel_out_q <= s2_ch_q;
      sample_out_q  <= sample_out_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = channel_out_q;
  assign sample_out_o  = sample_out_q;

  `BQHM_ASSERT_SAME(a_stall_blocks_input, out_valid_o && !out_ready_i, !in_ready_o, "stalled")
  `BQHM_ASSERT_NEXT(a_input_enters_pipe, in_valid_i && in_ready_o, s0_valid_q, "input lost")
  `BQHM_ASSERT_NEXT(a_result_reaches_out, s2_valid_q && adv, out_valid_o, "result beat lost")

endmodule

`default_nettype wire
